// ===== hw/rtl/manchester_frame_receiver_assert.svh =====
// Assertion macros for the Manchester frame receiver.
// Used by the top level; expects signals clk and rst_n in scope.
`ifndef MANCHESTER_FRAME_RECEIVER_ASSERT_SVH
`define MANCHESTER_FRAME_RECEIVER_ASSERT_SVH

// Checked only while reset is released.
`define MFR_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define MFR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/mfr_pkg.sv =====
// Shared types, constants and helper functions of the Manchester frame receiver.
// No dependencies; used by every module of the block.
package mfr_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 256;
  localparam int PREAMBLE_BYTES_DEF  = 4;
  localparam int OFIFO_DEPTH         = 4;

  localparam logic [7:0] PREAMBLE_RST  = 8'h00;
  localparam logic [7:0] IEEE_TYPE_RST = 8'h00;
  localparam logic [7:0] DFU_TYPE_RST  = 8'h01;
  localparam logic       DFU_EN_RST    = 1'b0;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ODD       = 3'd1,
    ST_PREAMBLE  = 3'd2,
    ST_SHORT     = 3'd3,
    ST_CRC       = 3'd4,
    ST_UNROUTED  = 3'd5,
    ST_TOO_LONG  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    CFG_PREAMBLE  = 2'd0,
    CFG_IEEE_TYPE = 2'd1,
    CFG_DFU_TYPE  = 2'd2,
    CFG_DFU_EN    = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] data_byte;
    logic [2:0] frame_status;
    logic [7:0] frame_type;
    logic       route_dfu;
    logic [8:0] payload_len;
    logic       manchester_error;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [7:0] preamble_value;
    logic [7:0] ieee_frame_type;
    logic [7:0] dfu_frame_type;
    logic       dfu_enable;
  } cfg_t;

  // Results produced by one processed word: count, then up to two entries.
  typedef struct packed {
    logic [1:0] n;
    out_t       first;
    out_t       second;
  } push_t;

  // A line byte is valid when every bit pair is 01 or 10.
  function automatic logic nib_valid(input logic [7:0] b);
    return (b[7] ^ b[6]) & (b[5] ^ b[4]) & (b[3] ^ b[2]) & (b[1] ^ b[0]);
  endfunction

  // The second bit of each pair carries the data bit, MSB pair first.
  function automatic logic [3:0] nib_value(input logic [7:0] b);
    return {b[6], b[4], b[2], b[0]};
  endfunction

  // One byte of reflected CRC16-CCITT (polynomial 0x8408), LSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] d);
    logic [7:0]  e;
    logic [7:0]  f;
    logic [15:0] f16;
    e   = crc[7:0] ^ d;
    f   = e ^ (e << 4);
    f16 = {8'h00, f};
    return {8'h00, crc[15:8]} ^ (f16 << 8) ^ (f16 << 3) ^ (f16 >> 4);
  endfunction

endpackage

// ===== hw/rtl/manchester_frame_receiver.sv =====
// Manchester frame receiver: one line byte per word in, decoded bytes and
// one end-of-frame status out. An accepted word waits in the input register
// and its results in the result queue. Throughput is one line byte per cycle
// while the queue has room for two results; a byte that yields a data byte
// and a status takes two words of the single-result output port behind a
// four-entry result queue. Reset (rst_n, synchronous) clears frame state and queue and loads defaults.
module manchester_frame_receiver #(
  parameter int MAX_FRAME_BYTES = mfr_pkg::MAX_FRAME_BYTES_DEF,
  parameter int PREAMBLE_BYTES  = mfr_pkg::PREAMBLE_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  mfr_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output mfr_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [7:0]    cfg_wdata
);

`include "manchester_frame_receiver_assert.svh"

  mfr_pkg::cfg_t  cfg_r;
  mfr_pkg::push_t push;
  logic           space2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.preamble_value  <= mfr_pkg::PREAMBLE_RST;
      cfg_r.ieee_frame_type <= mfr_pkg::IEEE_TYPE_RST;
      cfg_r.dfu_frame_type  <= mfr_pkg::DFU_TYPE_RST;
      cfg_r.dfu_enable      <= mfr_pkg::DFU_EN_RST;
    end else if (cfg_we) begin
      unique case (mfr_pkg::cfg_idx_t'(cfg_index))
        mfr_pkg::CFG_PREAMBLE:  cfg_r.preamble_value  <= cfg_wdata;
        mfr_pkg::CFG_IEEE_TYPE: cfg_r.ieee_frame_type <= cfg_wdata;
        mfr_pkg::CFG_DFU_TYPE:  cfg_r.dfu_frame_type  <= cfg_wdata;
        mfr_pkg::CFG_DFU_EN:    cfg_r.dfu_enable      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  mfr_core #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
    .PREAMBLE_BYTES  (PREAMBLE_BYTES)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .space2   (space2),
    .push     (push)
  );

  mfr_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space2    (space2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The queue must come out of reset empty.
  `MFR_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")
  `MFR_ASSERT_RST(a_kind_last, out_valid |-> (out_data.item_kind == out_data.last), "last mismatch")
  `MFR_ASSERT_RST(a_dfu_ok, (out_valid && out_data.route_dfu) |-> (out_data.frame_status == mfr_pkg::ST_OK), "dfu route on failed frame")
  `MFR_ASSERT_RST(a_data_clean, (out_valid && !out_data.item_kind) |-> (out_data.payload_len == 9'd0 && out_data.manchester_error == 1'b0), "status fields on data word")

endmodule

// ===== hw/rtl/mfr_core.sv =====
// Input register, frame state and per-word decode, CRC and status logic.
// Depends on mfr_pkg.
module mfr_core #(
  parameter int MAX_FRAME_BYTES = mfr_pkg::MAX_FRAME_BYTES_DEF,
  parameter int PREAMBLE_BYTES  = mfr_pkg::PREAMBLE_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  mfr_pkg::in_t   in_data,
  input  mfr_pkg::cfg_t  cfg,
  input  logic           space2,
  output mfr_pkg::push_t push
);

  localparam int RAW_CAP = PREAMBLE_BYTES + 2 * MAX_FRAME_BYTES + 2;
  localparam int RCW     = $clog2(RAW_CAP + 2);
  localparam int DCW     = $clog2(MAX_FRAME_BYTES + 1);
  localparam int LEN_CAP = (MAX_FRAME_BYTES < 511) ? MAX_FRAME_BYTES : 511;
  localparam logic PRE_ODD = 1'(PREAMBLE_BYTES % 2);

  logic          stage_vld_r;
  mfr_pkg::in_t  stage_r;
  logic          proc;

  logic [RCW-1:0] raw_r, raw_upd, raw_nxt;
  logic           pbad_r, pbad_upd, pbad_nxt;
  logic [3:0]     lown_r, lown_upd, lown_nxt;
  logic [DCW-1:0] dc_r, dc_upd, dc_nxt;
  logic [7:0]     hold0_r, hold0_upd, hold0_nxt;
  logic [7:0]     hold1_r, hold1_upd, hold1_nxt;
  logic [15:0]    crc_r, crc_upd, crc_nxt;
  logic [7:0]     type_r, type_upd, type_nxt;
  logic           cerr_r, cerr_upd, cerr_nxt;
  logic           ovf_r, ovf_upd, ovf_nxt;

  logic           data_emit;
  logic [7:0]     b;
  logic           endf;
  logic           bvalid;
  logic [3:0]     bnib;
  logic [DCW-1:0] len_full;
  logic [8:0]     len9;
  mfr_pkg::status_t st;
  logic           dfu;
  mfr_pkg::out_t  data_res;
  mfr_pkg::out_t  stat_res;

  assign proc     = stage_vld_r && space2;
  assign in_ready = !stage_vld_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_vld_r <= 1'b1;
    end else if (proc) begin
      stage_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_r <= in_data;
    end
  end

  assign b      = stage_r.line_byte;
  assign endf   = stage_r.frame_end;
  assign bvalid = mfr_pkg::nib_valid(b);
  assign bnib   = bvalid ? mfr_pkg::nib_value(b) : 4'h0;

  // Frame state update for the word in the input register.
  always_comb begin
    raw_upd   = raw_r;
    pbad_upd  = pbad_r;
    lown_upd  = lown_r;
    dc_upd    = dc_r;
    hold0_upd = hold0_r;
    hold1_upd = hold1_r;
    crc_upd   = crc_r;
    type_upd  = type_r;
    cerr_upd  = cerr_r;
    ovf_upd   = ovf_r;
    data_emit = 1'b0;

    if (raw_r < RCW'(PREAMBLE_BYTES)) begin
      if (b != cfg.preamble_value) begin
        pbad_upd = 1'b1;
      end
    end else if (!ovf_r && raw_r < RCW'(RAW_CAP)) begin
      if ((raw_r[0] ^ PRE_ODD) == 1'b0) begin
        lown_upd = bnib;
        if (!bvalid) begin
          cerr_upd = 1'b1;
        end
      end else if (dc_r >= DCW'(MAX_FRAME_BYTES)) begin
        ovf_upd = 1'b1;
      end else begin
        if (!bvalid) begin
          cerr_upd = 1'b1;
        end
        if (dc_r >= DCW'(2)) begin
          data_emit = 1'b1;
          crc_upd   = mfr_pkg::crc_byte(crc_r, hold0_r);
        end
        if (dc_r == DCW'(1)) begin
          type_upd = {bnib, lown_r};
        end
        hold0_upd = hold1_r;
        hold1_upd = {bnib, lown_r};
        dc_upd    = dc_r + DCW'(1);
      end
    end

    // Past the cap only the parity of the length is kept.
    if (raw_r >= RCW'(RAW_CAP)) begin
      raw_upd = raw_r ^ RCW'(1);
    end else begin
      raw_upd = raw_r + RCW'(1);
    end
  end

  // End-of-frame status from the updated state.
  always_comb begin
    len_full = (dc_upd >= DCW'(2)) ? (dc_upd - DCW'(2)) : '0;
    if (ovf_upd || len_full > DCW'(LEN_CAP)) begin
      len9 = 9'(LEN_CAP);
    end else begin
      len9 = 9'(len_full);
    end

    dfu = 1'b0;
    if (raw_upd[0]) begin
      st = mfr_pkg::ST_ODD;
    end else if (pbad_upd || raw_upd < RCW'(PREAMBLE_BYTES)) begin
      st = mfr_pkg::ST_PREAMBLE;
    end else if (ovf_upd) begin
      st = mfr_pkg::ST_TOO_LONG;
    end else if (dc_upd < DCW'(2)) begin
      st = mfr_pkg::ST_SHORT;
    end else if (crc_upd != {hold1_upd, hold0_upd}) begin
      st = mfr_pkg::ST_CRC;
    end else if (type_upd == cfg.ieee_frame_type) begin
      st = mfr_pkg::ST_OK;
    end else if (cfg.dfu_enable && type_upd == cfg.dfu_frame_type) begin
      st  = mfr_pkg::ST_OK;
      dfu = 1'b1;
    end else begin
      st = mfr_pkg::ST_UNROUTED;
    end
  end

  always_comb begin
    data_res                  = '0;
    data_res.item_kind        = mfr_pkg::KIND_DATA;
    data_res.data_byte        = hold0_r;

    stat_res                  = '0;
    stat_res.item_kind        = mfr_pkg::KIND_STATUS;
    stat_res.frame_status     = st;
    stat_res.frame_type       = type_upd;
    stat_res.route_dfu        = dfu;
    stat_res.payload_len      = len9;
    stat_res.manchester_error = cerr_upd;
    stat_res.last             = 1'b1;

    push.n      = proc ? (2'(data_emit) + 2'(endf)) : 2'd0;
    push.first  = data_emit ? data_res : stat_res;
    push.second = stat_res;
  end

  // A frame end returns the frame state to its reset value.
  always_comb begin
    if (endf) begin
      raw_nxt   = '0;
      pbad_nxt  = 1'b0;
      lown_nxt  = '0;
      dc_nxt    = '0;
      hold0_nxt = '0;
      hold1_nxt = '0;
      crc_nxt   = '0;
      type_nxt  = '0;
      cerr_nxt  = 1'b0;
      ovf_nxt   = 1'b0;
    end else begin
      raw_nxt   = raw_upd;
      pbad_nxt  = pbad_upd;
      lown_nxt  = lown_upd;
      dc_nxt    = dc_upd;
      hold0_nxt = hold0_upd;
      hold1_nxt = hold1_upd;
      crc_nxt   = crc_upd;
      type_nxt  = type_upd;
      cerr_nxt  = cerr_upd;
      ovf_nxt   = ovf_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r   <= '0;
      pbad_r  <= 1'b0;
      lown_r  <= '0;
      dc_r    <= '0;
      hold0_r <= '0;
      hold1_r <= '0;
      crc_r   <= '0;
      type_r  <= '0;
      cerr_r  <= 1'b0;
      ovf_r   <= 1'b0;
    end else if (proc) begin
      raw_r   <= raw_nxt;
      pbad_r  <= pbad_nxt;
      lown_r  <= lown_nxt;
      dc_r    <= dc_nxt;
      hold0_r <= hold0_nxt;
      hold1_r <= hold1_nxt;
      crc_r   <= crc_nxt;
      type_r  <= type_nxt;
      cerr_r  <= cerr_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

// ===== hw/rtl/mfr_out_fifo.sv =====
// Result queue: takes up to two results per cycle, delivers one per word.
// Depends on mfr_pkg.
module mfr_out_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  mfr_pkg::push_t push,
  output logic           space2,
  output logic           out_valid,
  input  logic           out_ready,
  output mfr_pkg::out_t  out_data
);

  localparam int DEPTH = mfr_pkg::OFIFO_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  mfr_pkg::out_t  mem [DEPTH];
  logic [PW-1:0]  wp_r, wp_nxt;
  logic [PW-1:0]  rp_r, rp_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem[rp_r];
  assign pop       = out_valid && out_ready;
  assign space2    = (cnt_r <= CW'(DEPTH - 2));

  always_comb begin
    wp_nxt  = wp_r + PW'(push.n);
    rp_nxt  = rp_r + PW'(pop);
    cnt_nxt = cnt_r + CW'(push.n) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wp_r] <= push.first;
    end
    if (push.n == 2'd2) begin
      mem[wp_r + PW'(1)] <= push.second;
    end
  end

endmodule
